// ===== rtl/tet_pkg.sv =====
package tet_pkg;

   localparam int SLOTS  = 16;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ID_W   = 16;
   localparam int TMO_W  = 32;
   localparam int NOW_W  = 48;
   localparam int DL_W   = 49;

   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);
   localparam logic [NOW_W-1:0]  NOW_MAX  = {NOW_W{1'b1}};

   localparam logic [1:0] CMD_REGISTER   = 2'd0;
   localparam logic [1:0] CMD_UNREGISTER = 2'd1;
   localparam logic [1:0] CMD_TICK       = 2'd2;
   localparam logic [1:0] CMD_SCAN       = 2'd3;

   localparam logic [2:0] STAT_REGISTERED = 3'd0;
   localparam logic [2:0] STAT_FULL       = 3'd1;
   localparam logic [2:0] STAT_REMOVED    = 3'd2;
   localparam logic [2:0] STAT_NOT_FOUND  = 3'd3;
   localparam logic [2:0] STAT_EXPIRED    = 3'd4;
   localparam logic [2:0] STAT_TICKED     = 3'd5;
   localparam logic [2:0] STAT_DONE       = 3'd6;

   typedef struct packed {
      logic [ID_W-1:0] event_id;
      logic [DL_W-1:0] deadline;
   } slot_entry_type;

endpackage

// ===== rtl/tet_slot_mem.sv =====
module tet_slot_mem (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [tet_pkg::SLOT_W-1:0] wr_addr,
   input  tet_pkg::slot_entry_type    wr_data,
   input  logic                       rd_en,
   input  logic [tet_pkg::SLOT_W-1:0] rd_addr,
   output tet_pkg::slot_entry_type    rd_data
);
   import tet_pkg::*;

   slot_entry_type slot_store_ff [SLOTS];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/timeout_event_table.sv =====
// channel  | ports                                        | direction
// ---------+----------------------------------------------+----------
// request  | req_valid req_ready req_command              | in
//          | req_event_id req_timeout_ms                  |
// response | rsp_valid rsp_ready rsp_result_id rsp_status | out
//          | rsp_last                                     |
//
// register and tick answer without a walk: free slot found from the valid
// flops, entry written to the slot memory in the accept cycle (register only).
// unregister and scan walk the slot memory: a valid slot is read, then
// compared, an empty slot is skipped without a read; a final beat closes the
// walk unless unregister finds its id; the slot memory has a single read port.
// reset clears state, valid bits, clock and the response valid flag.
// a response beat not taken holds the walk at a match or the final beat until rsp_ready.
module timeout_event_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_command,
   input  logic [tet_pkg::ID_W-1:0]  req_event_id,
   input  logic [tet_pkg::TMO_W-1:0] req_timeout_ms,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [tet_pkg::ID_W-1:0]  rsp_result_id,
   output logic [2:0]                rsp_status,
   output logic                      rsp_last
);
   import tet_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_CHECK = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              scan_ff, scan_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [NOW_W-1:0]  now_ff, now_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic              accept;
   logic              free_found;
   logic [SLOT_W-1:0] free_idx;
   logic              hit;
   state_type         adv_state;
   logic [SLOT_W-1:0] adv_idx;

   logic              wr_en;
   slot_entry_type    wr_data;
   logic              rd_en;
   slot_entry_type    rd_data;

   tet_slot_mem u_slot_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (free_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   assign wr_data.event_id = req_event_id;
   assign wr_data.deadline = DL_W'(now_ff) + DL_W'(req_timeout_ms);

   assign hit = scan_ff ? (rd_data.deadline < {1'b0, now_ff})
                        : (rd_data.event_id == id_ff);

   always_comb begin
      if (idx_ff == LAST_IDX) begin
         adv_state = S_DONE;
         adv_idx   = idx_ff;
      end else begin
         adv_state = S_READ;
         adv_idx   = idx_ff + 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      scan_in       = scan_ff;
      id_in         = id_ff;
      valid_in      = valid_ff;
      now_in        = now_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  CMD_REGISTER: begin
                     rsp_valid_in = 1'b1;
                     rsp_id_in    = req_event_id;
                     rsp_last_in  = 1'b1;
                     if (free_found) begin
                        wr_en              = 1'b1;
                        valid_in[free_idx] = 1'b1;
                        rsp_status_in      = STAT_REGISTERED;
                     end else begin
                        rsp_status_in = STAT_FULL;
                     end
                  end
                  CMD_UNREGISTER: begin
                     id_in    = req_event_id;
                     scan_in  = 1'b0;
                     idx_in   = '0;
                     state_in = S_READ;
                  end
                  CMD_TICK: begin
                     if (now_ff != NOW_MAX) begin
                        now_in = now_ff + 1'b1;
                     end
                     rsp_valid_in  = 1'b1;
                     rsp_id_in     = '0;
                     rsp_status_in = STAT_TICKED;
                     rsp_last_in   = 1'b1;
                  end
                  CMD_SCAN: begin
                     id_in    = req_event_id;
                     scan_in  = 1'b1;
                     idx_in   = '0;
                     state_in = S_READ;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_READ: begin
            if (valid_ff[idx_ff]) begin
               rd_en    = 1'b1;
               state_in = S_CHECK;
            end else begin
               state_in = adv_state;
               idx_in   = adv_idx;
            end
         end
         S_CHECK: begin
            if (hit) begin
               if (out_free) begin
                  valid_in[idx_ff] = 1'b0;
                  rsp_valid_in     = 1'b1;
                  if (scan_ff) begin
                     rsp_id_in     = rd_data.event_id;
                     rsp_status_in = STAT_EXPIRED;
                     rsp_last_in   = 1'b0;
                     state_in      = adv_state;
                     idx_in        = adv_idx;
                  end else begin
                     rsp_id_in     = id_ff;
                     rsp_status_in = STAT_REMOVED;
                     rsp_last_in   = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
            end else begin
               state_in = adv_state;
               idx_in   = adv_idx;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_id_in     = scan_ff ? '0 : id_ff;
               rsp_status_in = scan_ff ? STAT_DONE : STAT_NOT_FOUND;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      scan_ff       <= scan_in;
      id_ff         <= id_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_id = rsp_id_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

   a_check_valid_slot : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> valid_ff[idx_ff])
      else $error("compare stage on an empty slot");

   a_full_answer : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == CMD_REGISTER) && (&valid_ff))
      |=> (rsp_valid_ff && (rsp_status_ff == STAT_FULL) && (valid_ff == $past(valid_ff))))
      else $error("register on a full table changed state or missed full");

   a_tick_advance : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == CMD_TICK) && (now_ff != NOW_MAX))
      |=> (now_ff == $past(now_ff) + 1'b1))
      else $error("tick did not advance the clock");

   a_remove_one : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_CHECK) && !scan_ff && hit && out_free)
      |=> ($countones(valid_ff) == $countones($past(valid_ff)) - 1))
      else $error("unregister freed other than one slot");

endmodule

// ===== sim/timeout_event_table_test.sv =====
module timeout_event_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tet_pkg::*;

   typedef struct packed {
      logic [ID_W-1:0] result_id;
      logic [2:0]      status;
      logic            last;
   } response_beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_command = CMD_TICK;
   logic [ID_W-1:0]   req_event_id = '0;
   logic [TMO_W-1:0]  req_timeout_ms = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [ID_W-1:0]   rsp_result_id;
   logic [2:0]        rsp_status;
   logic              rsp_last;

   // shadow of the timer table
   bit                table_busy [SLOTS];
   logic [ID_W-1:0]   table_event [SLOTS];
   logic [DL_W-1:0]   table_deadline [SLOTS];
   logic [NOW_W-1:0]  ms_now;

   response_beat_type due_responses [$];

   bit                send_idle = 1'b0;
   bit                recv_idle = 1'b0;
   int unsigned       recv_hold_cycles = 0;

   int unsigned       requests_sent = 0;
   int unsigned       beats_checked = 0;
   int unsigned       expired_seen = 0;
   int unsigned       full_seen = 0;
   int unsigned       not_found_seen = 0;
   int unsigned       failures = 0;

   timeout_event_table DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_event_id   (req_event_id),
      .req_timeout_ms (req_timeout_ms),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_result_id  (rsp_result_id),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("timeout_event_table_test NOT OK");
      $finish;
   end

   function automatic void expect_beat(input logic [ID_W-1:0] id, input logic [2:0] status,
                                       input logic last);
      response_beat_type beat;
      beat.result_id = id;
      beat.status    = status;
      beat.last      = last;
      due_responses.push_back(beat);
   endfunction

   // applies one command to the shadow table and queues the beats it causes
   function automatic void advance_timer_table(input logic [1:0] cmd,
                                               input logic [ID_W-1:0] id,
                                               input logic [TMO_W-1:0] tmo);
      bit hit;
      hit = 1'b0;
      case (cmd)
         CMD_REGISTER: begin
            for (int s = 0; s < SLOTS; s++) begin
               if (!hit && !table_busy[s]) begin
                  table_busy[s]     = 1'b1;
                  table_event[s]    = id;
                  table_deadline[s] = DL_W'(ms_now) + DL_W'(tmo);
                  hit = 1'b1;
               end
            end
            expect_beat(id, hit ? STAT_REGISTERED : STAT_FULL, 1'b1);
         end
         CMD_UNREGISTER: begin
            for (int s = 0; s < SLOTS; s++) begin
               if (!hit && table_busy[s] && table_event[s] == id) begin
                  table_busy[s] = 1'b0;
                  hit = 1'b1;
               end
            end
            expect_beat(id, hit ? STAT_REMOVED : STAT_NOT_FOUND, 1'b1);
         end
         CMD_TICK: begin
            if (ms_now != NOW_MAX) ms_now = ms_now + 1'b1;
            expect_beat('0, STAT_TICKED, 1'b1);
         end
         default: begin
            for (int s = 0; s < SLOTS; s++) begin
               if (table_busy[s] && table_deadline[s] < DL_W'(ms_now)) begin
                  expect_beat(table_event[s], STAT_EXPIRED, 1'b0);
                  table_busy[s] = 1'b0;
               end
            end
            expect_beat('0, STAT_DONE, 1'b1);
         end
      endcase
   endfunction

   task automatic send_request(input logic [1:0] cmd, input logic [ID_W-1:0] id,
                               input logic [TMO_W-1:0] tmo);
      int unsigned gap;
      gap = send_idle ? $urandom_range(0, 13) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_event_id   <= id;
      req_timeout_ms <= tmo;
      do @(posedge clock); while (!req_ready);
      advance_timer_table(cmd, id, tmo);
      requests_sent++;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_responses.size() != 0) @(posedge clock);
   endtask

   // response sink: random stall per beat, optional long hold
   initial begin : response_sink
      int unsigned stall;
      while (reset) @(negedge clock);
      forever begin
         if (recv_hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (recv_hold_cycles) @(negedge clock);
            recv_hold_cycles = 0;
         end
         stall = recv_idle ? $urandom_range(0, 13) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : response_check
      response_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_responses.size() == 0) begin
            $error("unexpected beat: result_id %h status %0d last %b",
                   rsp_result_id, rsp_status, rsp_last);
            failures++;
         end else begin
            want = due_responses.pop_front();
            beats_checked++;
            if (want.status == STAT_EXPIRED) expired_seen++;
            if (want.status == STAT_FULL) full_seen++;
            if (want.status == STAT_NOT_FOUND) not_found_seen++;
            if (rsp_result_id !== want.result_id) begin
               $error("result_id: expected %h, got %h", want.result_id, rsp_result_id);
               failures++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_last);
               failures++;
            end
         end
      end
   end

   task automatic test_directed();
      send_idle = 1'b1;
      recv_idle = 1'b1;
      send_request(CMD_REGISTER, 16'h0000, 32'h0000_0000);
      send_request(CMD_REGISTER, 16'hFFFF, 32'hFFFF_FFFF);
      // deadline equal to now does not expire
      send_request(CMD_SCAN, 16'h0000, 32'h0000_0000);
      // ignored fields at their maximum
      send_request(CMD_TICK, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(CMD_SCAN, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(CMD_UNREGISTER, 16'hFFFF, 32'h0000_0000);
      // id absent
      send_request(CMD_UNREGISTER, 16'hFFFF, 32'h0000_0000);
      // duplicate ids, lowest slot goes first
      send_request(CMD_REGISTER, 16'h0005, 32'h0000_0000);
      send_request(CMD_REGISTER, 16'h0005, 32'h0000_0001);
      send_request(CMD_UNREGISTER, 16'h0005, 32'h0000_0000);
      send_request(CMD_TICK, 16'h0000, 32'h0000_0000);
      send_request(CMD_SCAN, 16'h0000, 32'h0000_0000);
      send_request(CMD_TICK, 16'h0000, 32'h0000_0000);
      send_request(CMD_SCAN, 16'h0000, 32'h0000_0000);
      send_request(CMD_UNREGISTER, 16'h0000, 32'h0000_0000);
   endtask

   task automatic test_table_full();
      send_idle = 1'b0;
      recv_idle = 1'b1;
      for (int k = 0; k < SLOTS; k++) begin
         send_request(CMD_REGISTER, 16'($urandom), 32'($urandom_range(0, 3)));
      end
      send_request(CMD_REGISTER, 16'hABCD, 32'h0000_0002);
      // free a middle slot and refill it
      send_request(CMD_UNREGISTER, table_event[SLOTS/2], 32'h0000_0000);
      send_request(CMD_REGISTER, 16'h0042, 32'h0000_0000);
      repeat (5) send_request(CMD_TICK, 16'($urandom), $urandom);
      // every slot expires in one scan
      send_request(CMD_SCAN, 16'h0000, 32'h0000_0000);
   endtask

   task automatic test_random_traffic(input int unsigned items);
      logic [ID_W-1:0]  id_pool [8];
      logic [ID_W-1:0]  id;
      logic [TMO_W-1:0] tmo;
      int unsigned      mode;
      int unsigned      pick;
      int unsigned      live [$];
      foreach (id_pool[k]) id_pool[k] = 16'($urandom);
      for (int n = 0; n < items; n++) begin
         if (n % 30 == 0) begin
            mode = $urandom_range(0, 3);
            send_idle = mode[0];
            recv_idle = mode[1];
         end
         id   = ($urandom_range(0, 4) == 0) ? 16'($urandom) : id_pool[$urandom_range(0, 7)];
         tmo  = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 15));
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            send_request(CMD_REGISTER, id, tmo);
         end else if (pick < 50) begin
            live.delete();
            for (int s = 0; s < SLOTS; s++) if (table_busy[s]) live.push_back(s);
            if (live.size() != 0 && $urandom_range(0, 2) != 0)
               id = table_event[live[$urandom_range(0, live.size() - 1)]];
            send_request(CMD_UNREGISTER, id, tmo);
         end else if (pick < 85) begin
            send_request(CMD_TICK, id, tmo);
         end else begin
            send_request(CMD_SCAN, id, tmo);
         end
      end
   endtask

   task automatic test_stall_and_drain();
      send_idle = 1'b0;
      recv_idle = 1'b0;
      recv_hold_cycles = 400;
      for (int k = 0; k < 20; k++) begin
         if (k % 2 == 0)
            send_request(CMD_REGISTER, 16'($urandom), 32'($urandom_range(0, 4)));
         else
            send_request(CMD_TICK, 16'($urandom), $urandom);
      end
      send_request(CMD_SCAN, 16'h0000, 32'h0000_0000);
      // sender waits for the table to answer everything
      wait_for_drain();
      send_idle = 1'b1;
      recv_idle = 1'b1;
      repeat (6) send_request(CMD_TICK, 16'h0000, 32'h0000_0000);
      send_request(CMD_SCAN, 16'h0000, 32'h0000_0000);
   endtask

   initial begin
      foreach (table_busy[s]) table_busy[s] = 1'b0;
      ms_now = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_table_full();
      test_random_traffic(260);
      test_stall_and_drain();

      @(negedge clock);
      req_valid <= 1'b0;
      wait_for_drain();
      repeat (2 * SLOTS + 8) @(posedge clock);
      if (due_responses.size() != 0) begin
         $error("%0d expected beats never arrived", due_responses.size());
         failures++;
      end

      $display("%0d requests sent, %0d response beats checked, %0d mismatches",
               requests_sent, beats_checked, failures);
      $display("%0d expirations, %0d table-full and %0d not-found answers seen",
               expired_seen, full_seen, not_found_seen);
      if (failures == 0)
         $display("timeout_event_table_test OK");
      else
         $display("timeout_event_table_test NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/tet_pkg.sv
rtl/tet_slot_mem.sv
rtl/timeout_event_table.sv
sim/timeout_event_table_test.sv
